// ----- hdl/olnb_pkg.sv -----
`timescale 1ns / 1ps

package olnb_pkg;

  localparam int CODE_BITS     = 48;
  localparam int MAX_CHILDREN  = 8;
  localparam int SUM_BITS      = 11;
  localparam int CNT_BITS      = 4;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int DIV_STEP_BITS = $clog2(SUM_BITS);

  localparam logic [47:0] CODE_MASK = 48'((64'd1 << CODE_BITS) - 64'd1);
  localparam logic [CNT_BITS-1:0] MAX_COUNT = CNT_BITS'(MAX_CHILDREN);

  typedef struct packed {
    logic [47:0] voxel_code;
    logic [23:0] voxel_color;
    logic        last_item;
  } in_item_t;

  typedef struct packed {
    logic [44:0] parent_code;
    logic [7:0]  child_mask;
    logic [23:0] average_color;
    logic        end_of_stream;
  } out_item_t;

  // one closed group as handed from the grouping side to the averaging side
  typedef struct packed {
    logic [44:0]                 parent;
    logic [7:0]                  mask;
    logic [2:0][SUM_BITS-1:0]    sums;
    logic [CNT_BITS-1:0]         count;
    logic                        eos;
  } node_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- hdl/olnb_front.sv -----
`timescale 1ns / 1ps

module olnb_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  olnb_pkg::in_item_t    in_data_i,
  input  olnb_pkg::queue_status_t q_status_i,
  output logic                  push_o,
  output olnb_pkg::node_rec_t   push_rec_o
);

  logic [47:0]                           code;
  logic [44:0]                           parent;
  logic [7:0]                            bit_sel;
  logic                                  accept;
  logic                                  same;
  logic [44:0]                           parent_q;
  logic [7:0]                            mask_q;
  logic [2:0][olnb_pkg::SUM_BITS-1:0]    sums_q;
  logic [olnb_pkg::CNT_BITS-1:0]         count_q;
  logic                                  open_q;
  logic                                  flush_q;
  logic                                  flush_push;

  assign code    = in_data_i.voxel_code & olnb_pkg::CODE_MASK;
  assign parent  = code[47:3];
  assign bit_sel = 8'(1) << code[2:0];

  assign in_stall_o = flush_q | q_status_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign same       = open_q & (parent == parent_q);
  assign flush_push = flush_q & ~q_status_i.full;

  // the open group leaves either when a new parent arrives or in the flush cycle
  assign push_o              = (accept & open_q & ~same) | flush_push;
  assign push_rec_o.parent   = parent_q;
  assign push_rec_o.mask     = mask_q;
  assign push_rec_o.sums     = sums_q;
  assign push_rec_o.count    = count_q;
  assign push_rec_o.eos      = flush_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      flush_q  <= 1'b0;
      parent_q <= '0;
      mask_q   <= '0;
      sums_q   <= '0;
      count_q  <= '0;
    end else if (accept) begin
      if (same) begin
        mask_q <= mask_q | bit_sel;
        if (count_q < olnb_pkg::MAX_COUNT) begin
          for (int l = 0; l < 3; l++) begin
            sums_q[l] <= sums_q[l] + olnb_pkg::SUM_BITS'(in_data_i.voxel_color[8*l +: 8]);
          end
          count_q <= count_q + 1'b1;
        end
      end else begin
        parent_q <= parent;
        mask_q   <= bit_sel;
        for (int l = 0; l < 3; l++) begin
          sums_q[l] <= olnb_pkg::SUM_BITS'(in_data_i.voxel_color[8*l +: 8]);
        end
        count_q <= olnb_pkg::CNT_BITS'(1);
        open_q  <= 1'b1;
      end
      flush_q <= in_data_i.last_item;
    end else if (flush_push) begin
      open_q  <= 1'b0;
      flush_q <= 1'b0;
    end
  end

endmodule

// ----- hdl/olnb_queue.sv -----
`timescale 1ns / 1ps

module olnb_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  olnb_pkg::node_rec_t     push_rec_i,
  input  logic                    pop_i,
  output olnb_pkg::node_rec_t     pop_rec_o,
  output olnb_pkg::queue_status_t status_o
);

  olnb_pkg::node_rec_t                  entries_q [olnb_pkg::QUEUE_DEPTH];
  logic [olnb_pkg::QPTR_BITS-1:0]       wr_ptr_q;
  logic [olnb_pkg::QPTR_BITS-1:0]       rd_ptr_q;
  logic [olnb_pkg::QPTR_BITS:0]         fill_q;
  logic                                 do_push;
  logic                                 do_pop;

  assign status_o.full  = (fill_q == (olnb_pkg::QPTR_BITS+1)'(olnb_pkg::QUEUE_DEPTH));
  assign status_o.empty = (fill_q == '0);
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign pop_rec_o      = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fill_q <= fill_q + (olnb_pkg::QPTR_BITS+1)'(do_push)
                       - (olnb_pkg::QPTR_BITS+1)'(do_pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full))
    else $error("node record offered to a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && status_o.empty))
    else $error("node record taken from an empty queue");

endmodule

// ----- hdl/olnb_back.sv -----
`timescale 1ns / 1ps

module olnb_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  olnb_pkg::queue_status_t q_status_i,
  input  olnb_pkg::node_rec_t     pop_rec_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output olnb_pkg::out_item_t     out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e                                 state_q;
  logic [olnb_pkg::DIV_STEP_BITS-1:0]     step_q;
  logic [44:0]                           parent_q;
  logic [7:0]                            mask_q;
  logic                                  eos_q;
  logic [olnb_pkg::CNT_BITS-1:0]         cnt_q;
  logic [2:0][olnb_pkg::SUM_BITS-1:0]    dvd_q, dvd_d;
  logic [2:0][olnb_pkg::SUM_BITS-1:0]    quo_q, quo_d;
  logic [2:0][olnb_pkg::CNT_BITS-1:0]    rem_q, rem_d;
  logic                                  out_valid_q;
  olnb_pkg::out_item_t                   out_data_q;
  logic                                  out_free;

  assign pop_o       = (state_q == ST_IDLE) & ~q_status_i.empty;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // one restoring division step per lane, remainder stays below the count
  always_comb begin
    logic [olnb_pkg::CNT_BITS:0] trial;
    logic                        ge;
    for (int l = 0; l < 3; l++) begin
      trial    = {rem_q[l], dvd_q[l][olnb_pkg::SUM_BITS-1]};
      ge       = trial >= {1'b0, cnt_q};
      rem_d[l] = ge ? olnb_pkg::CNT_BITS'(trial - {1'b0, cnt_q})
                    : trial[olnb_pkg::CNT_BITS-1:0];
      quo_d[l] = {quo_q[l][olnb_pkg::SUM_BITS-2:0], ge};
      dvd_d[l] = {dvd_q[l][olnb_pkg::SUM_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      parent_q    <= '0;
      mask_q      <= '0;
      eos_q       <= 1'b0;
      cnt_q       <= '0;
      dvd_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if ((state_q == ST_HOLD) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            parent_q <= pop_rec_i.parent;
            mask_q   <= pop_rec_i.mask;
            eos_q    <= pop_rec_i.eos;
            cnt_q    <= pop_rec_i.count;
            dvd_q    <= pop_rec_i.sums;
            quo_q    <= '0;
            rem_q    <= '0;
            step_q   <= '0;
            state_q  <= ST_DIV;
          end
        end
        ST_DIV: begin
          dvd_q  <= dvd_d;
          quo_q  <= quo_d;
          rem_q  <= rem_d;
          step_q <= step_q + 1'b1;
          if (step_q == olnb_pkg::DIV_STEP_BITS'(olnb_pkg::SUM_BITS - 1)) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_data_q.parent_code   <= parent_q;
            out_data_q.child_mask    <= mask_q;
            out_data_q.end_of_stream <= eos_q;
            // an empty group would divide by zero and averages to black
            if (cnt_q == '0) begin
              out_data_q.average_color <= '0;
            end else begin
              out_data_q.average_color <= {quo_q[2][7:0], quo_q[1][7:0], quo_q[0][7:0]};
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_quotient_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD && cnt_q != '0) |->
      (quo_q[0][olnb_pkg::SUM_BITS-1:8] == '0 && quo_q[1][olnb_pkg::SUM_BITS-1:8] == '0
       && quo_q[2][olnb_pkg::SUM_BITS-1:8] == '0))
    else $error("average does not fit a byte");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q != '0 && cnt_q <= olnb_pkg::MAX_COUNT))
    else $error("node record with a child count out of range");

endmodule

// ----- hdl/octree_level_node_builder.sv -----
`timescale 1ns / 1ps

// Builds one octree level from a Morton-sorted voxel stream: consecutive codes with the same
// parent (code >> 3) are merged into one node carrying the parent code, the 8-bit child mask
// and the per-byte truncated mean of up to eight child colours. The grouping side takes one
// item per cycle unless it stalls; after an item marked last it flushes its node, and input
// stalls during the flush. Closed nodes wait in a 4-entry queue for the averaging side, whose
// restoring divider takes one node at a time (a load step, eleven divide steps, then a step
// that hands the result to the output register once that register is free), and the input
// stalls once the queue is full.
module octree_level_node_builder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  olnb_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output olnb_pkg::out_item_t out_data_o
);

  logic                    push;
  olnb_pkg::node_rec_t     push_rec;
  logic                    pop;
  olnb_pkg::node_rec_t     pop_rec;
  olnb_pkg::queue_status_t q_status;

  olnb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .push_rec_o (push_rec)
  );

  olnb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .status_o   (q_status)
  );

  olnb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .pop_rec_i   (pop_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BACKPRESSURE_HOLD = 250;
  localparam int TAIL_CYCLES = 40;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  olnb_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  olnb_pkg::out_item_t out_data_o;

  // model of the open group
  logic [44:0]                   grp_parent;
  logic [7:0]                    grp_mask;
  logic [olnb_pkg::SUM_BITS-1:0] sum_lo;
  logic [olnb_pkg::SUM_BITS-1:0] sum_mid;
  logic [olnb_pkg::SUM_BITS-1:0] sum_hi;
  logic [olnb_pkg::CNT_BITS-1:0] grp_count;
  logic                          grp_open;

  olnb_pkg::out_item_t pending_nodes[$];
  int        errors;
  int        stuck_cycles;
  int        hold_left;
  logic      idle_allowed;
  logic      src_idle;

  octree_level_node_builder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic olnb_pkg::in_item_t voxel(input logic [47:0] code,
                                               input logic [23:0] color, input logic last);
    olnb_pkg::in_item_t it;
    it.voxel_code  = code;
    it.voxel_color = color;
    it.last_item   = last;
    return it;
  endfunction

  function automatic olnb_pkg::out_item_t close_group(input logic eos);
    olnb_pkg::out_item_t n;
    n.parent_code   = grp_parent;
    n.child_mask    = grp_mask;
    n.average_color = '0;
    if (grp_count != 0) begin
      n.average_color[7:0]   = 8'(sum_lo / grp_count);
      n.average_color[15:8]  = 8'(sum_mid / grp_count);
      n.average_color[23:16] = 8'(sum_hi / grp_count);
    end
    n.end_of_stream = eos;
    return n;
  endfunction

  task automatic merge_voxel(input olnb_pkg::in_item_t it);
    logic [47:0] code;
    logic [44:0] parent;
    code   = it.voxel_code & olnb_pkg::CODE_MASK;
    parent = code[47:3];
    if (grp_open && parent == grp_parent) begin
      grp_mask = grp_mask | (8'd1 << code[2:0]);
    end else begin
      if (grp_open) pending_nodes.push_back(close_group(1'b0));
      grp_parent = parent;
      grp_mask   = 8'd1 << code[2:0];
      sum_lo     = '0;
      sum_mid    = '0;
      sum_hi     = '0;
      grp_count  = '0;
      grp_open   = 1'b1;
    end
    // colors past the eighth child are dropped, mask bits still count
    if (grp_count < olnb_pkg::MAX_COUNT) begin
      sum_lo    = sum_lo + it.voxel_color[7:0];
      sum_mid   = sum_mid + it.voxel_color[15:8];
      sum_hi    = sum_hi + it.voxel_color[23:16];
      grp_count = grp_count + 1'b1;
    end
    if (it.last_item) begin
      pending_nodes.push_back(close_group(1'b1));
      grp_open = 1'b0;
    end
  endtask

  // valid stays high across back-to-back transfers
  task automatic send_voxel(input olnb_pkg::in_item_t it);
    int gap;
    if (idle_allowed && src_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    merge_voxel(it);
  endtask

  task automatic test_extremes();
    send_voxel(voxel(48'h0, 24'h000000, 1'b0));
    send_voxel(voxel(48'h7, 24'hffffff, 1'b0));
    send_voxel(voxel(48'hffff_ffff_ffff, 24'hffffff, 1'b0));
    send_voxel(voxel(48'hffff_ffff_fff8, 24'h000000, 1'b1));
    // after a flush parent zero must open a fresh group
    send_voxel(voxel(48'h0, 24'h123456, 1'b1));
  endtask

  task automatic test_saturation();
    logic [44:0] parent;
    int          k;
    parent = 45'h0123_4567_89ab;
    k = 0;
    for (int i = 0; i < 11; i++) begin
      send_voxel(voxel({parent, 3'(k)}, 24'($urandom), i == 10));
      if (i % 3 == 2 && k < 7) k = k + 2;
    end
  endtask

  task automatic test_revisit_and_last();
    logic [44:0] pa;
    logic [44:0] pb;
    pa = 45'h0000_0000_0100;
    pb = 45'h1555_5555_5555;
    send_voxel(voxel({pa, 3'd0}, 24'h0a0b0c, 1'b0));
    send_voxel(voxel({pa, 3'd3}, 24'hf0e0d0, 1'b0));
    send_voxel(voxel({pb, 3'd1}, 24'h808080, 1'b0));
    // old parent again, also marked last: two nodes from one transfer
    send_voxel(voxel({pa, 3'd5}, 24'h7f7f7f, 1'b1));
    send_voxel(voxel({pa, 3'd6}, 24'h010203, 1'b0));
    send_voxel(voxel({pa, 3'd7}, 24'hfefdfc, 1'b1));
  endtask

  // receiver holds off while the sender keeps going, one node per voxel
  task automatic test_backpressure();
    logic [44:0] parent;
    parent    = 45'($urandom);
    src_idle  = 1'b0;
    hold_left = BACKPRESSURE_HOLD;
    for (int i = 0; i < 60; i++) begin
      send_voxel(voxel({parent, 3'($urandom)}, 24'($urandom), $urandom_range(0, 15) == 0));
      parent = parent + 1'b1;
    end
    src_idle = 1'b1;
  endtask

  task automatic test_sorted_groups(input int n_voxels);
    logic [44:0] parent;
    logic [44:0] prev_parent;
    logic        last;
    int          left;
    int          size;
    int          k;
    left        = n_voxels;
    parent      = 45'({$urandom, $urandom});
    prev_parent = parent;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) size = $urandom_range(9, 14);
      else size = $urandom_range(1, 8);
      if (size > left) size = left;
      if ($urandom_range(0, 15) == 0) src_idle = !src_idle;
      k = $urandom_range(0, 7);
      for (int i = 0; i < size; i++) begin
        if (i == size - 1) last = ($urandom_range(0, 11) == 0);
        else last = ($urandom_range(0, 39) == 0);
        send_voxel(voxel({parent, 3'(k)}, 24'($urandom), last));
        k = k + $urandom_range(0, 2);
        if (k > 7) k = 7;
        left--;
      end
      case ($urandom_range(0, 19))
        0: begin
          prev_parent = parent;
          parent = 45'({$urandom, $urandom});
        end
        1: begin
          // unsorted: jump back to an earlier parent
          parent = prev_parent;
        end
        default: begin
          prev_parent = parent;
          parent = parent + 45'($urandom_range(1, 3));
        end
      endcase
    end
    src_idle = 1'b1;
  endtask

  task automatic test_noise(input int n_voxels);
    for (int i = 0; i < n_voxels; i++) begin
      send_voxel(voxel(48'({$urandom, $urandom}), 24'($urandom), $urandom_range(0, 7) == 0));
    end
  endtask

  task automatic test_quiet_tail();
    idle_allowed = 1'b0;
    test_sorted_groups(110);
    send_voxel(voxel(48'({$urandom, $urandom}), 24'($urandom), 1'b1));
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    errors       = 0;
    hold_left    = 0;
    idle_allowed = 1'b1;
    src_idle     = 1'b1;
    grp_parent   = '0;
    grp_mask     = '0;
    sum_lo       = '0;
    sum_mid      = '0;
    sum_hi       = '0;
    grp_count    = '0;
    grp_open     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_saturation();
    test_revisit_and_last();
    test_backpressure();
    test_sorted_groups(900);
    test_noise(150);
    test_quiet_tail();
    in_valid_i <= 1'b0;
    while (pending_nodes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver stall: random bursts, calm stretches, and the long hold-off
  initial begin
    int burst;
    int calm;
    burst       = 0;
    calm        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else begin
        if (calm > 0) calm--;
        else if ($urandom_range(0, 99) == 0) calm = $urandom_range(20, 120);
        if (idle_allowed && calm == 0 && $urandom_range(0, 5) == 0) begin
          burst = $urandom_range(1, 15) - 1;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    olnb_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_nodes.size() == 0) begin
        $display("%0t: unexpected node, expected none, actual %h", $time, out_data_o);
        errors++;
      end else begin
        want = pending_nodes.pop_front();
        if (out_data_o.parent_code !== want.parent_code) begin
          $display("%0t: parent_code expected %h actual %h", $time, want.parent_code,
                   out_data_o.parent_code);
          errors++;
        end
        if (out_data_o.child_mask !== want.child_mask) begin
          $display("%0t: child_mask expected %h actual %h", $time, want.child_mask,
                   out_data_o.child_mask);
          errors++;
        end
        if (out_data_o.average_color !== want.average_color) begin
          $display("%0t: average_color expected %h actual %h", $time, want.average_color,
                   out_data_o.average_color);
          errors++;
        end
        if (out_data_o.end_of_stream !== want.end_of_stream) begin
          $display("%0t: end_of_stream expected %b actual %b", $time, want.end_of_stream,
                   out_data_o.end_of_stream);
          errors++;
        end
      end
    end
  end

  // no transfer on either side for too long means the block is stuck
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
